@@ hw/rtl/tlik_pkg.sv @@
// Shared types and constants for the two-link arm inverse kinematics block.
// Holds status codes, datapath widths, CORDIC arctangent table and the side-band struct.
// No dependencies.
package tlik_pkg;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_REACH = 3'd1,
    ST_XPOS  = 3'd2,
    ST_YPOS  = 3'd3,
    ST_CLOSE = 3'd4
  } ik_status_t;

  // register index is paddr[2]
  localparam logic CFG_IDX_UPPER = 1'b0;
  localparam logic CFG_IDX_LOWER = 1'b1;

  localparam logic [15:0] UPPER_RST = 16'd3072;
  localparam logic [15:0] LOWER_RST = 16'd3840;

  localparam int SVAL_W    = 18;  // decoded coordinate, signed
  localparam int MAG_W     = 17;
  localparam int SQ_W      = 62;  // square root radicand
  localparam int ROOT_W    = 31;
  localparam int ISQ_LAT   = SQ_W / 2;
  localparam int CORDIC_IW = 50;
  localparam int ANG_W     = 26;  // angle in 2^-16 degree, signed

  localparam int ATAN_LEN = 24;
  localparam logic [22:0] ATAN_TAB [ATAN_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
  };

  typedef struct packed {
    ik_status_t               status;
    logic signed [SVAL_W-1:0] xs;
    logic signed [SVAL_W-1:0] zs;
    logic signed [31:0]       numn;
    logic [ROOT_W-1:0]        dnn;
    logic [46:0]              yy;
  } ik_side_t;

endpackage

@@ hw/rtl/tlik_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on tlik_pkg for widths.
module tlik_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tlik_pkg::SQ_W-1:0]     rad_i,
  output logic [tlik_pkg::ROOT_W-1:0]   root_o
);
  import tlik_pkg::*;

  localparam int STAGES = SQ_W / 2;

  logic [SQ_W-1:0] rem_r [STAGES-1];
  logic [SQ_W-1:0] res_r [STAGES];

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_stage
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);
      logic [SQ_W-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;

      if (g == 0) begin : g_first
        assign rem_in = rad_i;
        assign res_in = '0;
      end else begin : g_rest
        assign rem_in = rem_r[g-1];
        assign res_in = res_r[g-1];
      end

      always_comb begin
        trial = res_in + BIT;
        if (rem_in >= trial) begin
          rem_nxt = rem_in - trial;
          res_nxt = (res_in >> 1) + BIT;
        end else begin
          rem_nxt = rem_in;
          res_nxt = res_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          res_r[g] <= res_nxt;
        end
      end

      if (g < STAGES - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[g] <= rem_nxt;
          end
        end
      end else begin : g_norem
        // remainder of the last step is not needed
        logic unused_rem;
        assign unused_rem = ^rem_nxt;
      end
    end
  endgenerate

  assign root_o = res_r[STAGES-1][ROOT_W-1:0];

endmodule

@@ hw/rtl/tlik_cordic.sv @@
// Pipelined CORDIC vectoring atan2, result in 2^-16 degree over [-180, 180].
// Depends on tlik_pkg for widths and the arctangent table.
module tlik_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [tlik_pkg::CORDIC_IW-1:0] y_i,
  input  logic signed [tlik_pkg::CORDIC_IW-1:0] x_i,
  output logic signed [tlik_pkg::ANG_W-1:0]     ang_o
);
  import tlik_pkg::*;

  localparam int PW       = $clog2(CORDIC_IW);
  localparam int NORM_POS = 40;  // leading one lands in bit 40
  localparam int CW       = 44;
  localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);

  // flags: [2] x negative, [1] y negative, [0] zero vector
  logic [CORDIC_IW-1:0] ax_r, ay_r, ax2_r, ay2_r;
  logic [1:0]           sg_r, sg2_r;
  logic [PW-1:0]        lead_nxt, lead_r;
  logic                 zero_nxt, zero_r;
  logic [CORDIC_IW-1:0] mor, axs, ays;

  logic signed [CW-1:0]    cx_r  [STEPS];
  logic signed [CW-1:0]    cy_r  [STEPS];
  logic signed [ANG_W-1:0] ang_r [STEPS+1];
  logic [2:0]              fl_r  [STEPS+1];
  logic signed [ANG_W-1:0] fin_nxt, fin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= x_i[CORDIC_IW-1] ? CORDIC_IW'(-x_i) : CORDIC_IW'(x_i);
      ay_r <= y_i[CORDIC_IW-1] ? CORDIC_IW'(-y_i) : CORDIC_IW'(y_i);
      sg_r <= {x_i[CORDIC_IW-1], y_i[CORDIC_IW-1]};
    end
  end

  always_comb begin
    mor      = ax_r | ay_r;
    lead_nxt = '0;
    for (int i = 0; i < CORDIC_IW; i++) begin
      if (mor[i]) begin
        lead_nxt = PW'(i);
      end
    end
    zero_nxt = (mor == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r  <= ax_r;
      ay2_r  <= ay_r;
      sg2_r  <= sg_r;
      lead_r <= lead_nxt;
      zero_r <= zero_nxt;
    end
  end

  // scale both magnitudes so the larger sits in [2^40, 2^41)
  always_comb begin
    if (lead_r >= PW'(NORM_POS)) begin
      axs = ax2_r >> (lead_r - PW'(NORM_POS));
      ays = ay2_r >> (lead_r - PW'(NORM_POS));
    end else begin
      axs = ax2_r << (PW'(NORM_POS) - lead_r);
      ays = ay2_r << (PW'(NORM_POS) - lead_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]  <= $signed({{(CW-NORM_POS-1){1'b0}}, axs[NORM_POS:0]});
      cy_r[0]  <= $signed({{(CW-NORM_POS-1){1'b0}}, ays[NORM_POS:0]});
      ang_r[0] <= '0;
      fl_r[0]  <= {sg2_r, zero_r};
    end
  end

  genvar g;
  generate
    for (g = 0; g < STEPS; g++) begin : g_step
      logic signed [CW-1:0]    dx, dy, cx_nxt, cy_nxt;
      logic signed [ANG_W-1:0] ang_nxt;

      always_comb begin
        dx = cx_r[g] >>> g;
        dy = cy_r[g] >>> g;
        if (cy_r[g] > 0) begin
          cx_nxt  = cx_r[g] + dy;
          cy_nxt  = cy_r[g] - dx;
          ang_nxt = ang_r[g] + $signed(ANG_W'(ATAN_TAB[g]));
        end else begin
          cx_nxt  = cx_r[g] - dy;
          cy_nxt  = cy_r[g] + dx;
          ang_nxt = ang_r[g] - $signed(ANG_W'(ATAN_TAB[g]));
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ang_r[g+1] <= ang_nxt;
          fl_r[g+1]  <= fl_r[g];
        end
      end

      if (g < STEPS - 1) begin : g_vec
        always_ff @(posedge clk) begin
          if (en) begin
            cx_r[g+1] <= cx_nxt;
            cy_r[g+1] <= cy_nxt;
          end
        end
      end else begin : g_novec
        logic unused_vec;
        assign unused_vec = ^{cx_nxt, cy_nxt};
      end
    end
  endgenerate

  // clamp to the first quadrant, then fold by the input signs
  always_comb begin
    fin_nxt = ang_r[STEPS];
    if (fin_nxt < 0) begin
      fin_nxt = '0;
    end
    if (fin_nxt > DEG90) begin
      fin_nxt = DEG90;
    end
    if (fl_r[STEPS][2]) begin
      fin_nxt = DEG180 - fin_nxt;
    end
    if (fl_r[STEPS][1]) begin
      fin_nxt = -fin_nxt;
    end
    if (fl_r[STEPS][0]) begin
      fin_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign ang_o = fin_r;

endmodule

@@ hw/rtl/two_link_arm_inverse_kinematics.sv @@
// Two-link arm inverse kinematics, built around the 31-stage square root and the
// CORDIC_STEPS + 4 stage CORDIC units. Throughput one request per cycle; the whole
// pipeline holds while a result waits on out_tready.
// Synchronous active-low reset clears valid bits and sets link lengths to defaults.
// Depends on tlik_pkg, tlik_isqrt, tlik_cordic.
module two_link_arm_inverse_kinematics #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // target_x[15:0], target_y[31:16], target_z[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], waist_angle[18:3], shoulder_angle[34:19], elbow_angle[50:35]
  output logic [55:0] out_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlik_pkg::*;

  localparam logic [32:0] CMOD = 33'(1) << COORD_BITS;
  localparam int CL = CORDIC_STEPS + 4;

  function automatic logic signed [SVAL_W-1:0] coord(input logic [15:0] f);
    logic [32:0] low;
    logic [32:0] m;
    logic        neg;
    low = {17'b0, f} & (CMOD - 33'd1);
    neg = low[COORD_BITS-1];
    m   = neg ? CMOD - low : low;
    return neg ? -$signed({1'b0, m[MAG_W-1:0]}) : $signed({1'b0, m[MAG_W-1:0]});
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [SVAL_W-1:0] v);
    return v[SVAL_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // 2^-16 degree to 1/128 degree, round half up
  function automatic logic [15:0] rnd(input logic signed [ANG_W:0] v);
    logic signed [ANG_W:0] t;
    t = (v + 27'sd256) >>> 9;
    return t[15:0];
  endfunction

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  // configuration
  logic [15:0] upper_r, lower_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RST;
      lower_r <= LOWER_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        CFG_IDX_UPPER: upper_r <= pwdata[15:0];
        CFG_IDX_LOWER: lower_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_UPPER: prdata = {16'b0, upper_r};
      CFG_IDX_LOWER: prdata = {16'b0, lower_r};
      default:       prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // stage 1: decode coordinates
  logic                     vld1_r;
  logic signed [SVAL_W-1:0] xs1_r, ys1_r, zs1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (ce) begin
      vld1_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      xs1_r <= coord(in_tdata[15:0]);
      ys1_r <= coord(in_tdata[31:16]);
      zs1_r <= coord(in_tdata[47:32]);
    end
  end

  // stage 2: squares
  logic [MAG_W-1:0] ux1, uy1, uz1, uy2_r;
  logic [16:0]      reach1;
  logic [15:0]      diff1;
  logic             vld2_r;
  logic [33:0]      xsq2_r, ysq2_r, zsq2_r, reachsq2_r;
  logic [31:0]      l1sq2_r, l2sq2_r, l12_2_r, diffsq2_r;
  logic signed [SVAL_W-1:0] xs2_r, ys2_r, zs2_r;

  assign ux1    = mag(xs1_r);
  assign uy1    = mag(ys1_r);
  assign uz1    = mag(zs1_r);
  assign reach1 = {1'b0, upper_r} + {1'b0, lower_r};
  assign diff1  = (upper_r > lower_r) ? upper_r - lower_r : lower_r - upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (ce) begin
      vld2_r <= vld1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      xsq2_r     <= 34'(ux1) * 34'(ux1);
      ysq2_r     <= 34'(uy1) * 34'(uy1);
      zsq2_r     <= 34'(uz1) * 34'(uz1);
      reachsq2_r <= 34'(reach1) * 34'(reach1);
      l1sq2_r    <= 32'(upper_r) * 32'(upper_r);
      l2sq2_r    <= 32'(lower_r) * 32'(lower_r);
      l12_2_r    <= 32'(upper_r) * 32'(lower_r);
      diffsq2_r  <= 32'(diff1) * 32'(diff1);
      xs2_r      <= xs1_r;
      ys2_r      <= ys1_r;
      zs2_r      <= zs1_r;
      uy2_r      <= uy1;
    end
  end

  // stage 3: squared distance and checks
  logic [33:0] d2_2, rs3_r, d23_r;
  logic [32:0] lsum3_r, dn3_r;
  ik_status_t  st2, st3_r;
  logic        vld3_r;
  logic signed [SVAL_W-1:0] xs3_r, zs3_r;
  logic [MAG_W-1:0] uy3_r;

  always_comb begin
    d2_2 = xsq2_r + ysq2_r + zsq2_r;
    if (d2_2 > reachsq2_r) begin
      st2 = ST_REACH;
    end else if (xs2_r <= 0) begin
      st2 = ST_XPOS;
    end else if (ys2_r <= 0) begin
      st2 = ST_YPOS;
    end else if (d2_2 < {2'b0, diffsq2_r}) begin
      st2 = ST_CLOSE;
    end else begin
      st2 = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (ce) begin
      vld3_r <= vld2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      d23_r   <= d2_2;
      rs3_r   <= xsq2_r + zsq2_r;
      lsum3_r <= 33'(l1sq2_r) + 33'(l2sq2_r);
      dn3_r   <= {l12_2_r, 1'b0};
      st3_r   <= st2;
      xs3_r   <= xs2_r;
      zs3_r   <= zs2_r;
      uy3_r   <= uy2_r;
    end
  end

  // stage 4: cosine numerator, plane radius normalization count
  logic [5:0]         rs_lead;
  logic [4:0]         k3;
  logic               vld4_r;
  logic signed [35:0] num4_r;
  logic [32:0]        dn4_r;
  logic [33:0]        rs4_r;
  logic [4:0]         k4_r;
  ik_status_t         st4_r;
  logic signed [SVAL_W-1:0] xs4_r, zs4_r;
  logic [MAG_W-1:0]   uy4_r;

  always_comb begin
    rs_lead = '0;
    for (int i = 0; i < 34; i++) begin
      if (rs3_r[i]) begin
        rs_lead = 6'(i);
      end
    end
    // smallest k with rs * 4^k >= 2^60, capped at 30
    k3 = (rs3_r == '0) ? 5'd30 : 5'((7'd61 - 7'(rs_lead)) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (ce) begin
      vld4_r <= vld3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      num4_r <= $signed({2'b0, d23_r}) - $signed({3'b0, lsum3_r});
      dn4_r  <= dn3_r;
      rs4_r  <= rs3_r;
      k4_r   <= k3;
      st4_r  <= st3_r;
      xs4_r  <= xs3_r;
      zs4_r  <= zs3_r;
      uy4_r  <= uy3_r;
    end
  end

  // stage 5: bring the denominator below 2^31
  logic [34:0]       an4;
  logic [1:0]        sh4;
  logic              vld5_r, neg5_r, dn0_5_r;
  logic [34:0]       an5_r;
  logic [ROOT_W-1:0] dn5_r;
  logic [SQ_W-1:0]   rsn5_r;
  logic [46:0]       yy5_r;
  ik_status_t        st5_r;
  logic signed [SVAL_W-1:0] xs5_r, zs5_r;

  assign an4 = num4_r[35] ? 35'(-num4_r) : 35'(num4_r);
  assign sh4 = dn4_r[32] ? 2'd2 : (dn4_r[31] ? 2'd1 : 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (ce) begin
      vld5_r <= vld4_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      an5_r   <= an4 >> sh4;
      dn5_r   <= ROOT_W'(dn4_r >> sh4);
      neg5_r  <= num4_r[35];
      dn0_5_r <= (dn4_r == '0);
      rsn5_r  <= SQ_W'(rs4_r) << {k4_r, 1'b0};
      yy5_r   <= 47'(uy4_r) << k4_r;
      st5_r   <= st4_r;
      xs5_r   <= xs4_r;
      zs5_r   <= zs4_r;
    end
  end

  // stage 6: clamp cosine to [-1, 1], zero-length links give cosine 1
  logic [ROOT_W-1:0] ann5, dnn5;
  logic              neg5;
  logic              vld6_r;
  logic [ROOT_W-1:0] ann6_r;
  logic [SQ_W-1:0]   rsn6_r;
  ik_side_t          sd5, sd6_r;

  always_comb begin
    if (dn0_5_r) begin
      dnn5 = ROOT_W'(1);
      ann5 = ROOT_W'(1);
      neg5 = 1'b0;
    end else begin
      dnn5 = dn5_r;
      ann5 = (an5_r > 35'(dn5_r)) ? dn5_r : an5_r[ROOT_W-1:0];
      neg5 = neg5_r;
    end
    sd5.status = st5_r;
    sd5.xs     = xs5_r;
    sd5.zs     = zs5_r;
    sd5.numn   = neg5 ? -$signed({1'b0, ann5}) : $signed({1'b0, ann5});
    sd5.dnn    = dnn5;
    sd5.yy     = yy5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else if (ce) begin
      vld6_r <= vld5_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      ann6_r <= ann5;
      rsn6_r <= rsn5_r;
      sd6_r  <= sd5;
    end
  end

  // stage 7: squares of the normalized cosine terms
  logic            vld7_r;
  logic [SQ_W-1:0] dnsq7_r, ansq7_r, rsn7_r;
  ik_side_t        sd7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r <= 1'b0;
    end else if (ce) begin
      vld7_r <= vld6_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      dnsq7_r <= SQ_W'(sd6_r.dnn) * SQ_W'(sd6_r.dnn);
      ansq7_r <= SQ_W'(ann6_r) * SQ_W'(ann6_r);
      rsn7_r  <= rsn6_r;
      sd7_r   <= sd6_r;
    end
  end

  // stage 8: sine radicand
  logic            vld8_r;
  logic [SQ_W-1:0] rad8_r, rsn8_r;
  ik_side_t        sd8_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld8_r <= 1'b0;
    end else if (ce) begin
      vld8_r <= vld7_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      rad8_r <= dnsq7_r - ansq7_r;
      rsn8_r <= rsn7_r;
      sd8_r  <= sd7_r;
    end
  end

  // square roots: elbow sine and plane radius
  logic [ROOT_W-1:0] s_root, r_root;
  logic              isv_r [ISQ_LAT];
  ik_side_t          isd_r [ISQ_LAT];

  tlik_isqrt u_sqrt_sin (
    .clk    (clk),
    .en     (ce),
    .rad_i  (rad8_r),
    .root_o (s_root)
  );

  tlik_isqrt u_sqrt_rad (
    .clk    (clk),
    .en     (ce),
    .rad_i  (rsn8_r),
    .root_o (r_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ISQ_LAT; i++) begin
        isv_r[i] <= 1'b0;
      end
    end else if (ce) begin
      isv_r[0] <= vld8_r;
      for (int i = 1; i < ISQ_LAT; i++) begin
        isv_r[i] <= isv_r[i-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      isd_r[0] <= sd8_r;
      for (int i = 1; i < ISQ_LAT; i++) begin
        isd_r[i] <= isd_r[i-1];
      end
    end
  end

  // stage 9: offset-angle products
  ik_side_t           sdq;
  logic               vld9_r;
  logic [ROOT_W-1:0]  s9_r, r9_r;
  logic [46:0]        l2s9_r, l1dn9_r;
  logic signed [48:0] l2nm9_r;
  ik_side_t           sd9_r;

  assign sdq = isd_r[ISQ_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld9_r <= 1'b0;
    end else if (ce) begin
      vld9_r <= isv_r[ISQ_LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s9_r    <= s_root;
      r9_r    <= r_root;
      l2s9_r  <= 47'(lower_r) * 47'(s_root);
      l1dn9_r <= 47'(upper_r) * 47'(sdq.dnn);
      l2nm9_r <= 49'($signed({1'b0, lower_r})) * 49'(sdq.numn);
      sd9_r   <= sdq;
    end
  end

  // stage 10: CORDIC operands
  logic                        vld10_r;
  ik_status_t                  st10_r;
  logic signed [CORDIC_IW-1:0] el_y_r, el_x_r, of_y_r, of_x_r;
  logic signed [CORDIC_IW-1:0] hd_y_r, hd_x_r, ws_y_r, ws_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld10_r <= 1'b0;
    end else if (ce) begin
      vld10_r <= vld9_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      st10_r <= sd9_r.status;
      el_y_r <= CORDIC_IW'(s9_r);
      el_x_r <= CORDIC_IW'(sd9_r.numn);
      of_y_r <= CORDIC_IW'(l2s9_r);
      of_x_r <= CORDIC_IW'($signed({1'b0, l1dn9_r})) + CORDIC_IW'(l2nm9_r);
      hd_y_r <= CORDIC_IW'(sd9_r.yy);
      hd_x_r <= CORDIC_IW'(r9_r);
      ws_y_r <= CORDIC_IW'(sd9_r.zs);
      ws_x_r <= CORDIC_IW'(sd9_r.xs);
    end
  end

  logic signed [ANG_W-1:0] el_ang, of_ang, hd_ang, ws_ang;

  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_elbow (
    .clk (clk), .en (ce), .y_i (el_y_r), .x_i (el_x_r), .ang_o (el_ang)
  );
  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_offset (
    .clk (clk), .en (ce), .y_i (of_y_r), .x_i (of_x_r), .ang_o (of_ang)
  );
  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_head (
    .clk (clk), .en (ce), .y_i (hd_y_r), .x_i (hd_x_r), .ang_o (hd_ang)
  );
  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_waist (
    .clk (clk), .en (ce), .y_i (ws_y_r), .x_i (ws_x_r), .ang_o (ws_ang)
  );

  logic       cvld_r [CL];
  ik_status_t cst_r  [CL];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CL; i++) begin
        cvld_r[i] <= 1'b0;
      end
    end else if (ce) begin
      cvld_r[0] <= vld10_r;
      for (int i = 1; i < CL; i++) begin
        cvld_r[i] <= cvld_r[i-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      cst_r[0] <= st10_r;
      for (int i = 1; i < CL; i++) begin
        cst_r[i] <= cst_r[i-1];
      end
    end
  end

  // output register
  logic                  out_vld_r;
  ik_status_t            status_r;
  logic [15:0]           waist_r, shoulder_r, elbow_r;
  logic signed [ANG_W:0] shd_ang;

  assign shd_ang = 27'(hd_ang) - 27'(of_ang);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= cvld_r[CL-1];
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      status_r <= cst_r[CL-1];
      if (cst_r[CL-1] == ST_OK) begin
        waist_r    <= rnd(27'(ws_ang));
        shoulder_r <= rnd(shd_ang);
        elbow_r    <= rnd(27'(el_ang));
      end else begin
        waist_r    <= '0;
        shoulder_r <= '0;
        elbow_r    <= '0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, elbow_r, shoulder_r, waist_r, status_r};

  // rejected points carry zero angles
  ast_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (status_r != ST_OK) |-> (waist_r == '0) && (shoulder_r == '0) &&
      (elbow_r == '0))
    else $error("rejected point with nonzero angle");

  ast_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (status_r <= ST_CLOSE))
    else $error("status code out of range");

  // elbow comes from arccos, so it stays within 0..180 degrees
  ast_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (status_r == ST_OK) |->
      !elbow_r[15] && ($signed(elbow_r) <= 16'sd23040))
    else $error("elbow angle out of range");

endmodule
